>>> sv/dmc_pkg.sv
// dmc_pkg: shared types and constants of the direct-mapped write-back cache.
// Used by dmc_ctrl, dmc_datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dmc_pkg;

  localparam int NUM_LINES_DEF  = 32;
  localparam int LINE_BYTES_DEF = 8;
  localparam int ADDR_BITS_DEF  = 16;
  localparam int BYTE_W         = 8;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DEC0,
    ST_DEC1,
    ST_DEC2,
    ST_LOOKUP,
    ST_VB0,
    ST_VB1,
    ST_WB,
    ST_FILL,
    ST_ACCESS,
    ST_RESP
  } dmc_state_e;

  // controller -> datapath
  typedef struct packed {
    logic take_in;
    logic clr_wr;
    logic dec0;
    logic dec1;
    logic dec2;
    logic lookup;
    logic vb0;
    logic vb1;
    logic cnt_rst;
    logic wb_rd;
    logic fill_rd;
    logic fill_commit;
    logic acc_rd;
    logic acc_wr;
    logic out_load;
  } dmc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic hit;
    logic victim_dirty;
    logic cnt_done;
    logic is_write;
    logic out_busy;
  } dmc_stat_t;

endpackage

`default_nettype wire

>>> sv/direct_mapped_write_back_cache_top.sv
// Direct-mapped write-back, write-allocate byte cache in front of a backing
// memory of 2^ADDR_BITS bytes. After reset the block sweeps the backing memory
// to zero, one byte a cycle, with in_stall_o high. It then takes one access
// at a time. A miss on a clean or empty line refills it; a miss on a dirty
// line writes it back first and then refills it. Both transfers go byte by
// byte through the single-byte ports of the line store and of the backing
// memory. Writes return no result.
// Depends on dmc_pkg, dmc_ctrl and dmc_datapath.
`timescale 1ns / 1ps
`default_nettype none

module direct_mapped_write_back_cache_top #(
  parameter int NUM_LINES  = dmc_pkg::NUM_LINES_DEF,
  parameter int LINE_BYTES = dmc_pkg::LINE_BYTES_DEF,
  parameter int ADDR_BITS  = dmc_pkg::ADDR_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [ADDR_BITS-1:0]        address_i,
  input  wire logic                        operation_i,
  input  wire logic [dmc_pkg::BYTE_W-1:0]  write_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [dmc_pkg::BYTE_W-1:0]       read_data_o,
  output logic                             hit_o,
  output logic                             line_dirty_o
);
  import dmc_pkg::*;

  dmc_cmd_t  cmd;
  dmc_stat_t stat;

  dmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dmc_datapath #(
    .NUM_LINES  (NUM_LINES),
    .LINE_BYTES (LINE_BYTES),
    .ADDR_BITS  (ADDR_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .address_i    (address_i),
    .operation_i  (operation_i),
    .write_data_i (write_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o),
    .hit_o        (hit_o),
    .line_dirty_o (line_dirty_o)
  );

endmodule

`default_nettype wire

>>> sv/dmc_ctrl.sv
// dmc_ctrl: sequencing state machine of the cache.
// Depends on dmc_pkg; drives dmc_datapath through dmc_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module dmc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  dmc_pkg::dmc_stat_t     stat_i,
  output dmc_pkg::dmc_cmd_t      cmd_o
);
  import dmc_pkg::*;

  dmc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          state_d       = ST_DEC0;
        end
      end
      ST_DEC0: begin
        cmd_o.dec0 = 1'b1;
        state_d    = ST_DEC1;
      end
      ST_DEC1: begin
        cmd_o.dec1 = 1'b1;
        state_d    = ST_DEC2;
      end
      ST_DEC2: begin
        cmd_o.dec2 = 1'b1;
        state_d    = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        cmd_o.lookup  = 1'b1;
        cmd_o.cnt_rst = 1'b1;
        if (stat_i.hit) state_d = ST_ACCESS;
        else if (stat_i.victim_dirty) state_d = ST_VB0;
        else state_d = ST_FILL;
      end
      ST_VB0: begin
        cmd_o.vb0 = 1'b1;
        state_d   = ST_VB1;
      end
      ST_VB1: begin
        cmd_o.vb1 = 1'b1;
        state_d   = ST_WB;
      end
      ST_WB: begin
        // last byte's memory write lands in the cycle that sees cnt_done
        if (!stat_i.cnt_done) begin
          cmd_o.wb_rd = 1'b1;
        end else begin
          cmd_o.cnt_rst = 1'b1;
          state_d       = ST_FILL;
        end
      end
      ST_FILL: begin
        if (!stat_i.cnt_done) begin
          cmd_o.fill_rd = 1'b1;
        end else begin
          cmd_o.fill_commit = 1'b1;
          state_d           = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        if (stat_i.is_write) begin
          cmd_o.acc_wr = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          cmd_o.acc_rd = 1'b1;
          state_d      = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/dmc_datapath.sv
// dmc_datapath: address split, tag/state store, line store, backing memory
// and result register. Depends on dmc_pkg; commanded by dmc_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module dmc_datapath #(
  parameter int NUM_LINES  = dmc_pkg::NUM_LINES_DEF,
  parameter int LINE_BYTES = dmc_pkg::LINE_BYTES_DEF,
  parameter int ADDR_BITS  = dmc_pkg::ADDR_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  dmc_pkg::dmc_cmd_t                cmd_i,
  output dmc_pkg::dmc_stat_t               stat_o,
  input  wire logic [ADDR_BITS-1:0]        address_i,
  input  wire logic                        operation_i,
  input  wire logic [dmc_pkg::BYTE_W-1:0]  write_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [dmc_pkg::BYTE_W-1:0]       read_data_o,
  output logic                             hit_o,
  output logic                             line_dirty_o
);
  import dmc_pkg::*;

  localparam int OFF_W     = $clog2(LINE_BYTES);
  localparam int IDX_W     = $clog2(NUM_LINES);
  localparam int CNT_W     = $clog2(LINE_BYTES + 1);
  localparam int SPAN      = NUM_LINES * LINE_BYTES;
  localparam int TAG_RANGE = ((1 << ADDR_BITS) + SPAN - 1) / SPAN;
  localparam int TAG_W     = (TAG_RANGE > 1) ? $clog2(TAG_RANGE) : 1;
  localparam int LS_AW     = IDX_W + OFF_W;
  localparam int LS_DEPTH  = NUM_LINES << OFF_W;
  localparam int MEM_DEPTH = 1 << ADDR_BITS;
  localparam int PW        = 2 * ADDR_BITS + 1;

  // exact reciprocals: floor(x/d) = (x*ceil(2^(A+l)/d)) >> (A+l), l = clog2(d)
  localparam int L1 = $clog2(LINE_BYTES);
  localparam int S1 = ADDR_BITS + L1;
  localparam logic [ADDR_BITS:0] M1 =
      (ADDR_BITS+1)'(((64'd1 << S1) + 64'(LINE_BYTES) - 64'd1) / 64'(LINE_BYTES));
  localparam int L2 = $clog2(SPAN);
  localparam int S2 = ADDR_BITS + L2;
  localparam logic [ADDR_BITS:0] M2 =
      (ADDR_BITS+1)'(((64'd1 << S2) + 64'(SPAN) - 64'd1) / 64'(SPAN));

  localparam logic [ADDR_BITS-1:0] LB_C   = ADDR_BITS'(LINE_BYTES);
  localparam logic [ADDR_BITS-1:0] NL_C   = ADDR_BITS'(NUM_LINES);
  localparam logic [ADDR_BITS-1:0] SPAN_C = ADDR_BITS'(SPAN);

  // accepted item
  logic [ADDR_BITS-1:0] addr_q;
  logic                 op_q;
  logic [BYTE_W-1:0]    wdata_q;

  // address split
  logic [ADDR_BITS-1:0] q1_q;
  logic [TAG_W-1:0]     tag_q;
  logic [OFF_W-1:0]     off_q;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [PW-1:0]        prod1, prod2;

  // line state
  logic [NUM_LINES-1:0] line_valid_q;
  logic [NUM_LINES-1:0] line_dirty_q;
  logic [TAG_W-1:0]     line_tag_mem [NUM_LINES];
  logic [TAG_W-1:0]     tag_rd_q;
  logic                 hit_now;
  logic                 hit_q;

  // transfer sequencing
  logic [CNT_W-1:0]     cnt_q;
  logic [OFF_W-1:0]     pend_off_q;
  logic                 wb_pend_q, fill_pend_q;
  logic [ADDR_BITS-1:0] vbase_q;
  logic [ADDR_BITS-1:0] fbase;
  logic [ADDR_BITS-1:0] clr_q;

  // line store
  logic [BYTE_W-1:0]    line_mem [LS_DEPTH];
  logic [BYTE_W-1:0]    ls_rdata_q;
  logic                 ls_re, ls_we;
  logic [LS_AW-1:0]     ls_raddr, ls_waddr;
  logic [BYTE_W-1:0]    ls_wdata;

  // backing memory
  logic [BYTE_W-1:0]    back_mem [MEM_DEPTH];
  logic [BYTE_W-1:0]    mem_rdata_q;
  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_waddr, mem_raddr;
  logic [BYTE_W-1:0]    mem_wdata;

  // result register
  logic                 out_valid_q;
  logic [BYTE_W-1:0]    out_data_q;
  logic                 out_hit_q, out_dirty_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      addr_q  <= address_i;
      op_q    <= operation_i;
      wdata_q <= write_data_i;
    end
  end

  assign prod1 = PW'(addr_q) * PW'(M1);
  assign prod2 = PW'(addr_q) * PW'(M2);
  assign idx_d = IDX_W'(q1_q - ADDR_BITS'(ADDR_BITS'(tag_q) * NL_C));

  always_ff @(posedge clk_i) begin
    if (cmd_i.dec0) q1_q <= ADDR_BITS'(prod1 >> S1);
    if (cmd_i.dec1) begin
      tag_q <= TAG_W'(prod2 >> S2);
      off_q <= OFF_W'(addr_q - ADDR_BITS'(q1_q * LB_C));
    end
    if (cmd_i.dec2) begin
      idx_q    <= idx_d;
      tag_rd_q <= line_tag_mem[idx_d];
    end
    if (cmd_i.fill_commit) line_tag_mem[idx_q] <= tag_q;
  end

  assign hit_now = line_valid_q[idx_q] && (tag_rd_q == tag_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_valid_q <= '0;
      line_dirty_q <= '0;
    end else begin
      if (cmd_i.fill_commit) begin
        line_valid_q[idx_q] <= 1'b1;
        line_dirty_q[idx_q] <= 1'b0;
      end
      if (cmd_i.acc_wr) line_dirty_q[idx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) hit_q <= hit_now;
    if (cmd_i.vb0) vbase_q <= ADDR_BITS'(ADDR_BITS'(idx_q) * LB_C);
    else if (cmd_i.vb1) vbase_q <= vbase_q + ADDR_BITS'(ADDR_BITS'(tag_rd_q) * SPAN_C);
    if (cmd_i.wb_rd || cmd_i.fill_rd) pend_off_q <= cnt_q[OFF_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      wb_pend_q   <= 1'b0;
      fill_pend_q <= 1'b0;
      clr_q       <= '0;
    end else begin
      if (cmd_i.cnt_rst) cnt_q <= '0;
      else if (cmd_i.wb_rd || cmd_i.fill_rd) cnt_q <= cnt_q + CNT_W'(1);
      wb_pend_q   <= cmd_i.wb_rd;
      fill_pend_q <= cmd_i.fill_rd;
      if (cmd_i.clr_wr) clr_q <= clr_q + ADDR_BITS'(1);
    end
  end

  // line block base, wraps with the memory
  assign fbase = addr_q - ADDR_BITS'(off_q);

  assign ls_re    = cmd_i.wb_rd || cmd_i.acc_rd;
  assign ls_raddr = cmd_i.wb_rd ? {idx_q, cnt_q[OFF_W-1:0]} : {idx_q, off_q};
  assign ls_we    = fill_pend_q || cmd_i.acc_wr;
  assign ls_waddr = fill_pend_q ? {idx_q, pend_off_q} : {idx_q, off_q};
  assign ls_wdata = fill_pend_q ? mem_rdata_q : wdata_q;

  always_ff @(posedge clk_i) begin
    if (ls_we) line_mem[ls_waddr] <= ls_wdata;
    if (ls_re) ls_rdata_q <= line_mem[ls_raddr];
  end

  assign mem_we    = cmd_i.clr_wr || wb_pend_q;
  assign mem_waddr = cmd_i.clr_wr ? clr_q : vbase_q + ADDR_BITS'(pend_off_q);
  assign mem_wdata = cmd_i.clr_wr ? '0 : ls_rdata_q;
  assign mem_raddr = fbase + ADDR_BITS'(cnt_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) back_mem[mem_waddr] <= mem_wdata;
    if (cmd_i.fill_rd) mem_rdata_q <= back_mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q  <= ls_rdata_q;
      out_hit_q   <= hit_q;
      out_dirty_q <= line_dirty_q[idx_q];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = out_data_q;
  assign hit_o        = out_hit_q;
  assign line_dirty_o = out_dirty_q;

  always_comb begin
    stat_o              = '0;
    stat_o.clr_last     = &clr_q;
    stat_o.hit          = hit_now;
    stat_o.victim_dirty = line_valid_q[idx_q] && line_dirty_q[idx_q];
    stat_o.cnt_done     = (cnt_q == CNT_W'(LINE_BYTES));
    stat_o.is_write     = (op_q == OP_WRITE);
    stat_o.out_busy     = out_valid_q && out_stall_i;
  end

  a_pend_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wb_pend_q && fill_pend_q))
    else $error("write-back and fill transfers overlap");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && out_stall_i))
    else $error("result loaded over a stalled result");

  a_fill_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fill_commit |=> line_valid_q[idx_q] && !line_dirty_q[idx_q])
    else $error("filled line not valid and clean");

  a_wb_dirty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wb_rd |-> line_valid_q[idx_q] && line_dirty_q[idx_q])
    else $error("write-back of a line that is not dirty");

endmodule

`default_nettype wire

>>> bench/testbench.sv
// testbench: self-checking bench for direct_mapped_write_back_cache_top.
// Directed table, then random accesses under varied input idling and output
// stalls, checked against an in-bench model of the cache; depends on dmc_pkg and the top level.
`timescale 1ns / 1ps

module testbench;
  import dmc_pkg::*;

  localparam int N_LINES   = NUM_LINES_DEF;
  localparam int LINE_LEN  = LINE_BYTES_DEF;
  localparam int ADDR_W    = ADDR_BITS_DEF;
  localparam int OFF_W     = $clog2(LINE_LEN);
  localparam int IDX_W     = $clog2(N_LINES);
  localparam int TAG_W     = ADDR_W - OFF_W - IDX_W;
  localparam int N_DIRECTED = 25;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              hit;
    logic              line_dirty;
  } cache_reply_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              op;
    logic [BYTE_W-1:0] wdata;
    logic              typed;
    cache_reply_t      reply;
  } access_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [ADDR_W-1:0] address_i;
  logic              operation_i;
  logic [BYTE_W-1:0] write_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [BYTE_W-1:0] read_data_o;
  logic              hit_o;
  logic              line_dirty_o;

  // model of the cache and its backing memory
  logic [BYTE_W-1:0] mem_image  [2**ADDR_W];
  logic [BYTE_W-1:0] line_image [N_LINES*LINE_LEN];
  logic [TAG_W-1:0]  tag_image  [N_LINES];
  logic              valid_image[N_LINES];
  logic              dirty_image[N_LINES];

  cache_reply_t pending_replies[$];
  int           error_count;
  int           send_idle_pct;
  int           recv_stall_pct;

  // expected value typed in only where it is plain from the sequence
  access_row_t directed_rows [N_DIRECTED] = '{
    '{16'h0000, OP_READ,  8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{16'hFFFF, OP_READ,  8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{16'h0000, OP_WRITE, 8'hFF, 1'b0, '0},
    '{16'h0000, OP_READ,  8'h00, 1'b1, '{8'hFF, 1'b1, 1'b1}},
    '{16'hFFFF, OP_WRITE, 8'hA5, 1'b0, '0},
    '{16'hFFFF, OP_READ,  8'h00, 1'b1, '{8'hA5, 1'b1, 1'b1}},
    '{16'h0100, OP_READ,  8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{16'h0000, OP_READ,  8'h00, 1'b1, '{8'hFF, 1'b0, 1'b0}},
    '{16'h0207, OP_WRITE, 8'h5A, 1'b0, '0},
    '{16'h0207, OP_READ,  8'h00, 1'b0, '0},
    '{16'h0200, OP_READ,  8'h00, 1'b0, '0},
    '{16'h0300, OP_WRITE, 8'h01, 1'b0, '0},
    '{16'h0207, OP_READ,  8'h00, 1'b0, '0},
    '{16'h00F8, OP_READ,  8'h00, 1'b0, '0},
    '{16'hFF07, OP_READ,  8'h00, 1'b0, '0},
    '{16'hFFF8, OP_WRITE, 8'h00, 1'b0, '0},
    '{16'hFFFF, OP_READ,  8'h00, 1'b0, '0},
    '{16'h8000, OP_WRITE, 8'h80, 1'b0, '0},
    '{16'h8000, OP_READ,  8'h00, 1'b0, '0},
    '{16'h7FFF, OP_READ,  8'h00, 1'b0, '0},
    '{16'hFFF8, OP_READ,  8'h00, 1'b0, '0},
    '{16'h5555, OP_WRITE, 8'h55, 1'b0, '0},
    '{16'hAAAA, OP_WRITE, 8'hAA, 1'b0, '0},
    '{16'h5555, OP_READ,  8'h00, 1'b0, '0},
    '{16'hAAAA, OP_READ,  8'h00, 1'b0, '0}
  };

  direct_mapped_write_back_cache_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .address_i    (address_i),
    .operation_i  (operation_i),
    .write_data_i (write_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o),
    .hit_o        (hit_o),
    .line_dirty_o (line_dirty_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // one access through the model: on a miss the dirty victim's write-back and the refill, then the access
  function automatic void cache_access(input logic [ADDR_W-1:0] addr, input logic op,
                                       input logic [BYTE_W-1:0] wdata,
                                       output bit has_reply, output cache_reply_t reply);
    logic [OFF_W-1:0] off;
    logic [IDX_W-1:0] idx;
    logic [TAG_W-1:0] tg;
    bit               was_hit;
    int               base;
    off  = addr[OFF_W-1:0];
    idx  = addr[OFF_W +: IDX_W];
    tg   = addr[ADDR_W-1 -: TAG_W];
    base = int'(idx) * LINE_LEN;
    was_hit = valid_image[idx] && (tag_image[idx] == tg);
    if (!was_hit) begin
      if (valid_image[idx] && dirty_image[idx])
        for (int i = 0; i < LINE_LEN; i++)
          mem_image[{tag_image[idx], idx, OFF_W'(i)}] = line_image[base + i];
      for (int i = 0; i < LINE_LEN; i++)
        line_image[base + i] = mem_image[{tg, idx, OFF_W'(i)}];
      tag_image[idx]   = tg;
      valid_image[idx] = 1'b1;
      dirty_image[idx] = 1'b0;
    end
    has_reply = 1'b0;
    reply     = '0;
    if (op == OP_WRITE) begin
      line_image[base + off] = wdata;
      dirty_image[idx]       = 1'b1;
    end else begin
      has_reply        = 1'b1;
      reply.read_data  = line_image[base + off];
      reply.hit        = was_hit;
      reply.line_dirty = dirty_image[idx];
    end
  endfunction

  // valid is left high after the transfer; the next call decides whether it drops
  task automatic send_access(input logic [ADDR_W-1:0] addr, input logic op,
                             input logic [BYTE_W-1:0] wdata, input logic typed,
                             input cache_reply_t typed_reply);
    bit           has_reply;
    cache_reply_t reply;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    address_i    <= addr;
    operation_i  <= op;
    write_data_i <= wdata;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    cache_access(addr, op, wdata, has_reply, reply);
    if (has_reply) pending_replies.push_back(typed ? typed_reply : reply);
  endtask

  // mostly four hot tags, half the time over the narrow index range 0..7, so hits and evictions are common
  task automatic random_phase(input int n_items, input int idle_pct, input int stall_pct);
    logic [TAG_W-1:0]  hot_tags [4];
    logic [ADDR_W-1:0] addr;
    logic [IDX_W-1:0]  idx;
    hot_tags[0] = '0;
    hot_tags[1] = TAG_W'(1);
    hot_tags[2] = '1;
    hot_tags[3] = TAG_W'($urandom);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n_items) begin
      if ($urandom_range(4) == 0) begin
        addr = ADDR_W'($urandom_range(2**ADDR_W - 1));
      end else begin
        idx  = $urandom_range(1) ? IDX_W'($urandom_range(7)) : IDX_W'($urandom);
        addr = {hot_tags[$urandom_range(3)], idx, OFF_W'($urandom)};
      end
      send_access(addr, ($urandom_range(9) < 4) ? OP_WRITE : OP_READ,
                  BYTE_W'($urandom_range(255)), 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    cache_reply_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected read result: read_data %0h hit %0b line_dirty %0b",
               read_data_o, hit_o, line_dirty_o);
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        if (read_data_o !== want.read_data) begin
          $error("read_data: expected %0h, got %0h", want.read_data, read_data_o);
          error_count++;
        end
        if (hit_o !== want.hit) begin
          $error("hit: expected %0b, got %0b", want.hit, hit_o);
          error_count++;
        end
        if (line_dirty_o !== want.line_dirty) begin
          $error("line_dirty: expected %0b, got %0b", want.line_dirty, line_dirty_o);
          error_count++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    in_valid_i     = 1'b0;
    address_i      = '0;
    operation_i    = OP_READ;
    write_data_i   = '0;
    out_stall_i    = 1'b0;
    rst_ni         = 1'b0;
    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (mem_image[i]) mem_image[i] = '0;
    foreach (line_image[i]) line_image[i] = '0;
    foreach (tag_image[i]) begin
      tag_image[i]   = '0;
      valid_image[i] = 1'b0;
      dirty_image[i] = 1'b0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // first transfer is held off by the memory clearing sweep after reset
    foreach (directed_rows[i])
      send_access(directed_rows[i].addr, directed_rows[i].op, directed_rows[i].wdata,
                  directed_rows[i].typed, directed_rows[i].reply);

    random_phase(135, 0, 0);
    random_phase(135, 82, 0);
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    random_phase(135, 0, 82);
    random_phase(135, 35, 35);

    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    // a trailing write may still be refilling its line
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS direct_mapped_write_back_cache_top");
    end else begin
      $display("FAIL direct_mapped_write_back_cache_top");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("FAIL direct_mapped_write_back_cache_top");
    $finish;
  end

endmodule
